// File: design/dcts_pkg.sv
// shared types, constants and timing helpers for the dram command timing scheduler
package dcts_pkg;

	localparam logic [2:0] OP_ACT = 3'd0;
	localparam logic [2:0] OP_PRE = 3'd1;
	localparam logic [2:0] OP_RD  = 3'd2;
	localparam logic [2:0] OP_WR  = 3'd3;
	localparam logic [2:0] OP_REF = 3'd4;

	localparam logic [2:0] BURST_NONE = 3'd4;

	localparam logic [1:0] CFG_TA = 2'd0;
	localparam logic [1:0] CFG_TB = 2'd1;
	localparam logic [1:0] CFG_BL = 2'd2;

	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;

	typedef struct packed {
		logic        cmd;
		logic [2:0]  dram_op;
		logic        rank_no;
		logic [2:0]  bank_no;
		logic [15:0] row_no;
		logic [2:0]  burst_kind;
	} in_word_t;

	typedef struct packed {
		logic        issued;
		logic [2:0]  out_op;
		logic        out_rank;
		logic [2:0]  out_bank;
		logic [15:0] out_row;
		logic [8:0]  data_start_delay;
		logic        enqueue_dropped;
		logic [4:0]  queue_count;
	} out_word_t;

	typedef struct packed {
		logic [63:0] ta;
		logic [55:0] tb;
		logic [31:0] bl;
	} timing_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// byte k of a timing word, widened for gap arithmetic
	function automatic logic signed [11:0] fa(input timing_t t, input int k);
		fa = $signed({4'd0, t.ta[8*k +: 8]});
	endfunction

	function automatic logic signed [11:0] fb(input timing_t t, input int k);
		fb = $signed({4'd0, t.tb[8*k +: 8]});
	endfunction

	function automatic logic signed [11:0] burst_len(input timing_t t, input logic [2:0] kind);
		burst_len = (kind > 3'd3) ? 12'sd0 : $signed({4'd0, t.bl[8*kind[1:0] +: 8]});
	endfunction

	function automatic logic signed [11:0] smax(input logic signed [11:0] a,
	                                          input logic signed [11:0] b);
		smax = (a >= b) ? a : b;
	endfunction

	// required gap after prev before cur; bit 10 of the result flags never allowed
	function automatic logic [10:0] gap(input timing_t t, input logic [2:0] cur,
	                                    input logic [2:0] prev, input logic sr,
	                                    input logic sb, input logic signed [11:0] bl);
		logic signed [11:0] g;
		logic               nv;
		logic               ssb;
		g   = fa(t, 0);
		nv  = 1'b0;
		ssb = sr & sb;
		unique case (prev)
			OP_ACT: begin
				if (cur == OP_ACT) begin
					if (ssb) nv = 1'b1; else if (sr) g = fa(t, 1);
				end else if (cur == OP_PRE) begin
					if (ssb) g = fa(t, 2);
				end else if (cur == OP_RD || cur == OP_WR) begin
					if (ssb) g = fa(t, 3) - fa(t, 4);
				end else if (cur == OP_REF) begin
					if (sr) g = fa(t, 2);
				end
			end
			OP_PRE: begin
				if (cur == OP_ACT) begin
					if (sr && !sb) g = fa(t, 5);
				end else if (cur == OP_PRE) begin
					if (ssb) g = fa(t, 5); else if (!sr) g = fa(t, 6);
				end else if (cur == OP_RD || cur == OP_WR) begin
					if (ssb) nv = 1'b1;
				end else if (cur == OP_REF) begin
					g = sr ? fa(t, 5) : fa(t, 6);
				end
			end
			OP_RD: begin
				if (cur == OP_ACT) begin
					if (ssb) nv = 1'b1;
				end else if (cur == OP_PRE || cur == OP_REF) begin
					if ((cur == OP_PRE && ssb) || (cur == OP_REF && sr))
						g = fa(t, 4) + bl + fa(t, 7) - fb(t, 0);
				end else if (cur == OP_RD) begin
					g = smax(bl, fb(t, 0)) + (sr ? 12'sd0 : fa(t, 6));
				end else if (cur == OP_WR) begin
					g = fb(t, 1) + bl + fa(t, 6) - fb(t, 2);
				end
			end
			OP_WR: begin
				if (cur == OP_ACT) begin
					if (ssb) nv = 1'b1;
				end else if (cur == OP_PRE || cur == OP_REF) begin
					if ((cur == OP_PRE && ssb) || (cur == OP_REF && sr))
						g = fa(t, 4) + bl + fb(t, 2) + fb(t, 3);
				end else if (cur == OP_RD) begin
					g = sr ? fb(t, 2) + bl + fb(t, 4) : fb(t, 2) + bl + fa(t, 6) - fb(t, 1);
				end else if (cur == OP_WR) begin
					g = smax(bl, fb(t, 0)) + (sr ? 12'sd0 : fb(t, 5));
				end
			end
			OP_REF: g = sr ? fb(t, 6) : fa(t, 6);
			default: g = fa(t, 0);
		endcase
		gap = {nv, (g < 0) ? 10'd0 : g[9:0]};
	endfunction

	// timing check: t + g <= now without wrap
	function automatic logic past(input logic [31:0] t, input logic [9:0] g,
	                              input logic [31:0] now);
		past = ({1'b0, t} + 33'(g)) <= {1'b0, now};
	endfunction

endpackage

// File: design/dram_command_timing_scheduler_unit.sv
// top level of the dram command timing scheduler
// Usage: pulse start with a word on in_data while busy is low. An enqueue word
// appends a command to the queue; a tick word advances time one cycle and
// issues the oldest eligible command. Every accepted word gives exactly one
// result word on out_data, flagged by done for one cycle in ST_DONE after
// ST_SCAN; busy is high through both states, so no new word is taken before it.
// The queue is a row of cells that each judge their own entry in parallel;
// a priority pick over the row chooses the oldest eligible one and the cells
// behind it shift forward by one slot in the same edge.
// Timing registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// write them only while idle (the block does not enforce it); cfg_ready is always high.
// Reset clears the queue count, time, bus reservation and bank history; the
// timing registers read zero. The receiver cannot stall: done lasts one cycle.
module dram_command_timing_scheduler_unit import dcts_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int RANKS = 2,
	parameter int BANKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    in_data,
	output logic        done,
	output out_word_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int NH = RANKS * BANKS;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t      state_q, state_d;
	in_word_t    in_q;
	timing_t     tim_q;
	logic [CW-1:0] count_q;
	logic [31:0] now_q, bus_q, last_time_q;
	logic [25:0] last_q;
	logic        last_valid_q;
	logic [3*NH-1:0]  hist_op_q;
	logic [32*NH-1:0] hist_time_q;
	out_word_t   res_q;
	logic        done_q;

	logic [25:0]      cdata [QUEUE_DEPTH];
	logic [BANKS-1:0] ob [QUEUE_DEPTH+1];
	logic             okv [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] elig;
	logic [QUEUE_DEPTH-1:0] pick;
	logic             any;
	logic [25:0]      sel;
	logic [31:0]      now1;
	logic             is_tick;
	logic             do_enq;
	logic             rank_w;
	logic [2:0]       bank_w;

	// bank number folded into the configured bank count, as a small constant table
	function automatic logic [2:0] bank_wrap(input logic [2:0] v);
		bank_wrap = '0;
		for (int i = 0; i < 8; i++)
			if (v == 3'(i)) bank_wrap = 3'(i % BANKS);
	endfunction

	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign out_data = res_q;
	assign now1 = now_q + 32'd1;
	assign is_tick = in_q.cmd;
	assign do_enq = !in_q.cmd && in_q.dram_op <= OP_REF && count_q < CW'(QUEUE_DEPTH);
	assign rank_w = (RANKS > 1) ? in_q.rank_no : 1'b0;
	assign bank_w = bank_wrap(in_q.bank_no);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy) in_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tim_q <= '0;
		else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TA: tim_q.ta <= cfg_data;
				CFG_TB: tim_q.tb <= cfg_data[55:0];
				CFG_BL: tim_q.bl <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign ob[0] = '0;
	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic ld, sh;
			logic [25:0] nxt;
			assign ld = (state_q == ST_SCAN) && do_enq && count_q == CW'(gi);
			assign sh = (state_q == ST_SCAN) && is_tick && any && |(pick & ((QUEUE_DEPTH)'(1) << gi) - 1'b1 | pick & ((QUEUE_DEPTH)'(1) << gi));
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign nxt = cdata[gi];
			end else begin : g_mid
				assign nxt = cdata[gi+1];
			end
			dcts_cell #(.RANKS(RANKS), .BANKS(BANKS)) u_cell (
				.clk(clk), .arst_n(arst_n), .load(ld),
				.load_data({in_q.dram_op, rank_w, bank_w, in_q.row_no,
				            (in_q.burst_kind > BURST_NONE) ? BURST_NONE : in_q.burst_kind}),
				.shift(sh), .next_data(nxt), .valid(CW'(gi) < count_q),
				.older_bank_in(ob[gi]), .older_bank_out(ob[gi+1]),
				.ok_in(1'b1), .ok_out(okv[gi]), .tim(tim_q), .now(now1),
				.bus_free(bus_q < now1), .last_op(last_q[25:23]), .last_burst(last_q[2:0]),
				.last_rank({3'd0, last_q[22]}), .last_bank({2'd0, last_q[21:19]}),
				.last_valid(last_valid_q), .last_time(last_time_q),
				.hist_op(hist_op_q), .hist_time(hist_time_q), .data(cdata[gi]));
			assign elig[gi] = okv[gi];
		end
	endgenerate

	always_comb begin
		pick = '0;
		sel = '0;
		any = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (elig[i] && !any) begin
				pick[i] = 1'b1;
				sel = cdata[i];
				any = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			now_q <= '0;
			bus_q <= '0;
			last_q <= {OP_PRE, 20'd0, BURST_NONE};
			last_time_q <= '0;
			last_valid_q <= 1'b0;
			for (int h = 0; h < NH; h++) begin
				hist_op_q[3*h +: 3] <= OP_PRE;
				hist_time_q[32*h +: 32] <= '0;
			end
			res_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				res_q <= '0;
				if (!is_tick) begin
					if (do_enq) count_q <= count_q + 1'b1;
					res_q.enqueue_dropped <= !do_enq && in_q.dram_op <= OP_REF;
					res_q.queue_count <= 5'(do_enq ? count_q + 1'b1 : count_q);
				end else begin
					now_q <= now1;
					res_q.queue_count <= 5'(any ? count_q - 1'b1 : count_q);
					if (any) begin
						count_q <= count_q - 1'b1;
						res_q.issued <= 1'b1;
						res_q.out_op <= sel[25:23];
						res_q.out_rank <= sel[22];
						res_q.out_bank <= sel[21:19];
						res_q.out_row <= sel[18:3];
						if (sel[25:23] == OP_WR)
							res_q.data_start_delay <= 9'(tim_q.tb[23:16]) + 9'(tim_q.ta[7:0]) + 9'd1;
						if (sel[25:23] == OP_RD || sel[25:23] == OP_WR)
							bus_q <= now1 + 32'(tim_q.ta[7:0]) + 32'(burst_len(tim_q, sel[2:0]));
						last_q <= sel;
						last_time_q <= now1;
						last_valid_q <= 1'b1;
						hist_op_q[3*(int'(sel[22])*BANKS + int'(sel[21:19])) +: 3] <= sel[25:23];
						hist_time_q[32*(int'(sel[22])*BANKS + int'(sel[21:19])) +: 32] <= now1;
					end
				end
			end
		end
	end

	a_done_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> done) else $error("missing result");
	a_one_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick)) else $error("multiple picks");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("queue overflow");

endmodule

// File: design/dcts_cell.sv
// one queue slot: holds an entry, shifts toward the head, evaluates its own eligibility
module dcts_cell import dcts_pkg::*; #(
	parameter int RANKS = 2,
	parameter int BANKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [25:0]       load_data,
	input  logic              shift,
	input  logic [25:0]       next_data,
	input  logic              valid,
	input  logic [BANKS-1:0]  older_bank_in,
	output logic [BANKS-1:0]  older_bank_out,
	input  logic              ok_in,
	output logic              ok_out,
	input  timing_t           tim,
	input  logic [31:0]       now,
	input  logic              bus_free,
	input  logic [2:0]        last_op,
	input  logic [2:0]        last_burst,
	input  logic [3:0]        last_rank,
	input  logic [4:0]        last_bank,
	input  logic              last_valid,
	input  logic [31:0]       last_time,
	input  logic [3*RANKS*BANKS-1:0]  hist_op,
	input  logic [32*RANKS*BANKS-1:0] hist_time,
	output logic [25:0]       data
);

	logic [25:0] data_q;
	logic [2:0]  op;
	logic [3:0]  rk;
	logic [4:0]  bk;
	logic        bank_ok;
	logic        last_ok;
	logic [10:0] g;
	logic [10:0] gl;
	logic signed [11:0] bl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) data_q <= '0;
		else if (load) data_q <= load_data;
		else if (shift) data_q <= next_data;
	end
	assign data = data_q;

	assign op = data_q[25:23];
	assign rk = {3'd0, data_q[22]};
	assign bk = {2'd0, data_q[21:19]};
	assign bl = burst_len(tim, last_burst);

	always_comb begin
		bank_ok = 1'b1;
		g = '0;
		for (int b = 0; b < BANKS; b++) begin
			if (op == OP_REF || b == int'(bk)) begin
				g = gap(tim, op, hist_op[3*(int'(rk)*BANKS+b) +: 3], 1'b1, 1'b1, bl);
				if (g[10] || !past(hist_time[32*(int'(rk)*BANKS+b) +: 32], g[9:0], now))
					bank_ok = 1'b0;
			end
		end
	end

	always_comb begin
		gl = gap(tim, op, last_op, last_valid && last_rank == rk,
		         last_valid && last_bank == bk, bl);
		last_ok = !gl[10] && past(last_time, gl[9:0], now);
	end

	// older entries' banks ride down the chain
	assign older_bank_out = valid ? (older_bank_in | (BANKS'(1) << bk)) : older_bank_in;
	assign ok_out = valid && !older_bank_in[bk[$clog2(BANKS > 1 ? BANKS : 2)-1:0]]
	                && (bus_free || !(op == OP_RD || op == OP_WR)) && bank_ok && last_ok
	                && ok_in;

endmodule
